>>> rtl/core/attitude_altitude_pid_bank_macros.svh
// Assertion macros for the PID bank.
`ifndef ATTITUDE_ALTITUDE_PID_BANK_MACROS_SVH
`define ATTITUDE_ALTITUDE_PID_BANK_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AAPB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aapb: same-cycle check failed");

`define AAPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aapb: next-cycle check failed");

`else

`define AAPB_ASSERT_SAME(label, ante, cons)

`define AAPB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/aapb_pkg.sv
package aapb_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ERR_W    = SAMPLE_W + 2;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int INTEG_W  = 24;
  localparam int GAIN_W   = 48;
  localparam int COEF_W   = 16;
  localparam int NUM_CH   = 5;
  localparam int MA_W     = 29;
  localparam int MB_W     = 28;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int ACC_W    = 56;
  localparam int U_W      = 27;
  localparam int ALT_W    = 17;
  localparam int DRIVE_W  = 32;

  localparam logic signed [ERR_W-1:0]   DEG180    = ERR_W'(46080);
  localparam logic signed [ERR_W-1:0]   DEG360    = ERR_W'(92160);
  localparam logic signed [INTEG_W+3:0] INT_LIMIT = (INTEG_W+4)'(6553600);
  localparam logic signed [ALT_W-1:0]   ALT_LIMIT = ALT_W'(38400);
  // e/25 via reciprocal: u = e + 25*2^21 keeps the dividend positive
  localparam int                        DIV_K_LOG = 21;
  localparam logic [U_W-1:0]            DIV_BIAS  = U_W'(25 * (2 ** DIV_K_LOG));
  localparam logic [MA_W-1:0]           RECIP_25  = MA_W'(171798692);
  localparam logic [U_W-1:0]            DIV_25    = U_W'(25);

  typedef enum logic [2:0] {
    CH_PITCH = 3'd0,
    CH_ROLL  = 3'd1,
    CH_YAW   = 3'd2,
    CH_ALT   = 3'd3,
    CH_VACC  = 3'd4
  } chan_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ERR,
    OP_RECIP,
    OP_FIXQ,
    OP_INTEG,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC_D,
    OP_FIN,
    OP_PUBLISH
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_RECIP,
    ST_FIXQ,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_FIN,
    ST_PUB
  } state_e;

  typedef struct packed {
    op_e   op;
    chan_e ch;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // floor((256*r + 50) / 100) for r = e mod 25
  function automatic logic [6:0] inc_frac(input logic [4:0] r);
    logic [6:0] v;
    unique case (r)
      5'd0:  v = 7'd0;
      5'd1:  v = 7'd3;
      5'd2:  v = 7'd5;
      5'd3:  v = 7'd8;
      5'd4:  v = 7'd10;
      5'd5:  v = 7'd13;
      5'd6:  v = 7'd15;
      5'd7:  v = 7'd18;
      5'd8:  v = 7'd20;
      5'd9:  v = 7'd23;
      5'd10: v = 7'd26;
      5'd11: v = 7'd28;
      5'd12: v = 7'd31;
      5'd13: v = 7'd33;
      5'd14: v = 7'd36;
      5'd15: v = 7'd38;
      5'd16: v = 7'd41;
      5'd17: v = 7'd44;
      5'd18: v = 7'd46;
      5'd19: v = 7'd49;
      5'd20: v = 7'd51;
      5'd21: v = 7'd54;
      5'd22: v = 7'd56;
      5'd23: v = 7'd59;
      5'd24: v = 7'd61;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/aapb_ctrl.sv
module aapb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             cmd_i,
  output logic             in_stall_o,
  input  aapb_pkg::status_t status_i,
  output aapb_pkg::cmd_t    cmd_o
);

  aapb_pkg::state_e state_q, state_d;
  aapb_pkg::chan_e  ch_q, ch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aapb_pkg::ST_IDLE;
      ch_q    <= aapb_pkg::CH_PITCH;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    cmd_o.op   = aapb_pkg::OP_NONE;
    cmd_o.ch   = ch_q;
    in_stall_o = (state_q != aapb_pkg::ST_IDLE);
    unique case (state_q)
      aapb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i) begin
            cmd_o.op = aapb_pkg::OP_CLEAR;
          end else begin
            cmd_o.op = aapb_pkg::OP_LOAD;
            ch_d     = aapb_pkg::CH_PITCH;
            state_d  = aapb_pkg::ST_ERR;
          end
        end
      end
      aapb_pkg::ST_ERR: begin
        cmd_o.op = aapb_pkg::OP_ERR;
        state_d  = aapb_pkg::ST_RECIP;
      end
      aapb_pkg::ST_RECIP: begin
        cmd_o.op = aapb_pkg::OP_RECIP;
        state_d  = aapb_pkg::ST_FIXQ;
      end
      aapb_pkg::ST_FIXQ: begin
        cmd_o.op = aapb_pkg::OP_FIXQ;
        state_d  = aapb_pkg::ST_INTEG;
      end
      aapb_pkg::ST_INTEG: begin
        cmd_o.op = aapb_pkg::OP_INTEG;
        state_d  = aapb_pkg::ST_MUL_P;
      end
      aapb_pkg::ST_MUL_P: begin
        cmd_o.op = aapb_pkg::OP_MUL_P;
        state_d  = aapb_pkg::ST_MUL_I;
      end
      aapb_pkg::ST_MUL_I: begin
        cmd_o.op = aapb_pkg::OP_MUL_I;
        state_d  = aapb_pkg::ST_MUL_D;
      end
      aapb_pkg::ST_MUL_D: begin
        cmd_o.op = aapb_pkg::OP_MUL_D;
        state_d  = aapb_pkg::ST_ACC_D;
      end
      aapb_pkg::ST_ACC_D: begin
        cmd_o.op = aapb_pkg::OP_ACC_D;
        state_d  = aapb_pkg::ST_FIN;
      end
      aapb_pkg::ST_FIN: begin
        cmd_o.op = aapb_pkg::OP_FIN;
        if (ch_q == aapb_pkg::CH_VACC) begin
          state_d = aapb_pkg::ST_PUB;
        end else begin
          ch_d    = aapb_pkg::chan_e'(ch_q + 3'd1);
          state_d = aapb_pkg::ST_ERR;
        end
      end
      aapb_pkg::ST_PUB: begin
        // hold the finished beat until the output register frees up
        if (!status_i.out_busy) begin
          cmd_o.op = aapb_pkg::OP_PUBLISH;
          state_d  = aapb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aapb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/aapb_dp.sv
module aapb_dp (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  aapb_pkg::cmd_t                            cmd_i,
  output aapb_pkg::status_t                         status_o,
  input  logic                                      cfg_we_i,
  input  logic [2:0]                                cfg_idx_i,
  input  logic [aapb_pkg::GAIN_W-1:0]               cfg_data_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      pitch_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      roll_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      yaw_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      altitude_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      pitch_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      roll_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      yaw_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      altitude_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0]      vertical_accel_i,
  input  logic                                      out_stall_i,
  output logic                                      out_valid_o,
  output logic signed [aapb_pkg::DRIVE_W-1:0]       roll_drive_o,
  output logic signed [aapb_pkg::DRIVE_W-1:0]       pitch_drive_o,
  output logic signed [aapb_pkg::DRIVE_W-1:0]       yaw_drive_o,
  output logic signed [aapb_pkg::ALT_W-1:0]         altitude_drive_o
);

  localparam int EW = aapb_pkg::ERR_W;
  localparam int SW = aapb_pkg::SAMPLE_W;

  logic [aapb_pkg::GAIN_W-1:0] gains_q [aapb_pkg::NUM_CH];

  logic signed [aapb_pkg::INTEG_W-1:0]     integ_q [aapb_pkg::NUM_CH];
  logic signed [EW-1:0]                    prev_q  [aapb_pkg::NUM_CH];
  logic [aapb_pkg::NUM_CH-1:0]             primed_q;

  logic signed [SW-1:0] pt_q, rt_q, yt_q, at_q, pm_q, rm_q, ym_q, am_q, va_q;

  logic signed [EW-1:0]                    e_q;
  logic signed [aapb_pkg::DIFF_W-1:0]      diff_q;
  logic [aapb_pkg::U_W-1:0]                u_q;
  logic signed [aapb_pkg::PROD_W-1:0]      p_q;
  logic signed [aapb_pkg::U_W-1:0]         a_q;
  logic [4:0]                              r_q;
  logic signed [aapb_pkg::ACC_W-1:0]       acc_q;

  logic signed [aapb_pkg::DRIVE_W-1:0]     roll_w_q, pitch_w_q, yaw_w_q;
  logic signed [aapb_pkg::ALT_W-1:0]       alt_w_q;

  logic [2:0] ch;
  assign ch = cmd_i.ch;

  logic [aapb_pkg::GAIN_W-1:0] g;
  logic signed [aapb_pkg::COEF_W-1:0] kp, ki, kd;
  assign g  = gains_q[ch];
  assign kp = g[47:32];
  assign ki = g[31:16];
  assign kd = g[15:0];

  assign status_o.out_busy = out_valid_o && out_stall_i;

  // channel error
  logic signed [EW-1:0] tgt, meas, e_raw, e_c;
  always_comb begin
    tgt = '0;
    meas = '0;
    unique case (cmd_i.ch)
      aapb_pkg::CH_PITCH: begin tgt = EW'(pt_q); meas = EW'(pm_q); end
      aapb_pkg::CH_ROLL:  begin tgt = EW'(rt_q); meas = EW'(rm_q); end
      aapb_pkg::CH_YAW:   begin tgt = EW'(yt_q); meas = EW'(ym_q); end
      aapb_pkg::CH_ALT:   begin tgt = EW'(at_q); meas = EW'(am_q); end
      aapb_pkg::CH_VACC:  begin tgt = '0;        meas = EW'(va_q); end
      default:            begin tgt = '0;        meas = '0;        end
    endcase
    e_raw = tgt - meas;
    e_c   = e_raw;
    if (cmd_i.ch == aapb_pkg::CH_YAW) begin
      if (e_raw > aapb_pkg::DEG180) begin
        e_c = e_raw - aapb_pkg::DEG360;
      end else if (e_raw < -aapb_pkg::DEG180) begin
        e_c = e_raw + aapb_pkg::DEG360;
      end
    end
  end

  // shared multiplier
  logic signed [aapb_pkg::MA_W-1:0]   ma;
  logic signed [aapb_pkg::MB_W-1:0]   mb;
  logic signed [aapb_pkg::PROD_W-1:0] prod;
  always_comb begin
    ma = aapb_pkg::MA_W'(kp);
    mb = aapb_pkg::MB_W'(e_q);
    unique case (cmd_i.op)
      aapb_pkg::OP_RECIP: begin
        ma = aapb_pkg::RECIP_25;
        mb = {1'b0, u_q};
      end
      aapb_pkg::OP_MUL_I: begin
        ma = aapb_pkg::MA_W'(ki);
        mb = aapb_pkg::MB_W'(integ_q[ch]);
      end
      aapb_pkg::OP_MUL_D: begin
        ma = aapb_pkg::MA_W'(kd);
        mb = aapb_pkg::MB_W'(diff_q);
      end
      default: begin
        ma = aapb_pkg::MA_W'(kp);
        mb = aapb_pkg::MB_W'(e_q);
      end
    endcase
    prod = ma * mb;
  end

  // quotient fix-up: q = floor(u/25), r = u - 25q
  logic [aapb_pkg::U_W-1:0] q_est, r_est, q_fix, r_fix;
  always_comb begin
    q_est = aapb_pkg::U_W'(p_q[aapb_pkg::PROD_W-1:32]);
    r_est = u_q - aapb_pkg::U_W'(q_est * aapb_pkg::DIV_25);
    q_fix = q_est;
    r_fix = r_est;
    if (r_est >= aapb_pkg::DIV_25) begin
      q_fix = q_est + aapb_pkg::U_W'(1);
      r_fix = r_est - aapb_pkg::DIV_25;
    end
  end

  // integral update with clamp
  logic signed [aapb_pkg::INTEG_W+3:0] inc, isum, iclamp;
  always_comb begin
    inc  = ((aapb_pkg::INTEG_W+4)'(a_q) <<< 6) + (aapb_pkg::INTEG_W+4)'({1'b0, aapb_pkg::inc_frac(r_q)});
    isum = (aapb_pkg::INTEG_W+4)'(integ_q[ch]) + inc;
    if (isum > aapb_pkg::INT_LIMIT) begin
      iclamp = aapb_pkg::INT_LIMIT;
    end else if (isum < -aapb_pkg::INT_LIMIT) begin
      iclamp = -aapb_pkg::INT_LIMIT;
    end else begin
      iclamp = isum;
    end
  end

  // rounding and saturation of the channel sum
  logic signed [aapb_pkg::ACC_W-1:0] rnd_full;
  logic signed [47:0]                rnd;
  logic signed [aapb_pkg::DRIVE_W-1:0] sat32;
  logic signed [aapb_pkg::ALT_W-1:0]   sat_alt;
  always_comb begin
    rnd_full = (acc_q + aapb_pkg::ACC_W'(128)) >>> 8;
    rnd      = rnd_full[47:0];
    if (rnd > 48'sh0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (rnd < -48'sh0000_8000_0000) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = rnd[31:0];
    end
    if (rnd > 48'(aapb_pkg::ALT_LIMIT)) begin
      sat_alt = aapb_pkg::ALT_LIMIT;
    end else if (rnd < -48'(aapb_pkg::ALT_LIMIT)) begin
      sat_alt = -aapb_pkg::ALT_LIMIT;
    end else begin
      sat_alt = rnd[aapb_pkg::ALT_W-1:0];
    end
  end

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aapb_pkg::NUM_CH; i++) begin
        gains_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < 3'(aapb_pkg::NUM_CH))) begin
      gains_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aapb_pkg::NUM_CH; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
      end
      primed_q <= '0;
    end else if (cmd_i.op == aapb_pkg::OP_CLEAR) begin
      for (int i = 0; i < aapb_pkg::NUM_CH; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
      end
      primed_q <= '0;
    end else if (cmd_i.op == aapb_pkg::OP_INTEG) begin
      integ_q[ch]  <= iclamp[aapb_pkg::INTEG_W-1:0];
      prev_q[ch]   <= e_q;
      primed_q[ch] <= 1'b1;
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      aapb_pkg::OP_LOAD: begin
        pt_q <= pitch_target_i;
        rt_q <= roll_target_i;
        yt_q <= yaw_target_i;
        at_q <= altitude_target_i;
        pm_q <= pitch_meas_i;
        rm_q <= roll_meas_i;
        ym_q <= yaw_meas_i;
        am_q <= altitude_meas_i;
        va_q <= vertical_accel_i;
      end
      aapb_pkg::OP_ERR: begin
        e_q    <= e_c;
        // unprimed channel takes its own error as the previous one
        diff_q <= primed_q[ch] ? (aapb_pkg::DIFF_W'(e_c) - aapb_pkg::DIFF_W'(prev_q[ch]))
                               : '0;
        u_q    <= aapb_pkg::U_W'(e_c) + aapb_pkg::DIV_BIAS;
      end
      aapb_pkg::OP_RECIP: begin
        p_q <= prod;
      end
      aapb_pkg::OP_FIXQ: begin
        a_q <= $signed(q_fix) - $signed(aapb_pkg::U_W'(2 ** aapb_pkg::DIV_K_LOG));
        r_q <= r_fix[4:0];
      end
      aapb_pkg::OP_MUL_P: begin
        p_q <= prod;
      end
      aapb_pkg::OP_MUL_I: begin
        p_q   <= prod;
        // acceleration channel adds onto the altitude sum
        acc_q <= ((cmd_i.ch == aapb_pkg::CH_VACC) ? acc_q : '0) + aapb_pkg::ACC_W'(p_q);
      end
      aapb_pkg::OP_MUL_D: begin
        p_q   <= prod;
        acc_q <= acc_q + aapb_pkg::ACC_W'(p_q >>> 8);
      end
      aapb_pkg::OP_ACC_D: begin
        acc_q <= acc_q + (aapb_pkg::ACC_W'(p_q) <<< 6) + (aapb_pkg::ACC_W'(p_q) <<< 5)
                       + (aapb_pkg::ACC_W'(p_q) <<< 2);
      end
      aapb_pkg::OP_FIN: begin
        unique case (cmd_i.ch)
          aapb_pkg::CH_PITCH: pitch_w_q <= sat32;
          aapb_pkg::CH_ROLL:  roll_w_q  <= sat32;
          aapb_pkg::CH_YAW:   yaw_w_q   <= sat32;
          aapb_pkg::CH_VACC:  alt_w_q   <= sat_alt;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.op == aapb_pkg::OP_PUBLISH) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == aapb_pkg::OP_PUBLISH) begin
      roll_drive_o     <= roll_w_q;
      pitch_drive_o    <= pitch_w_q;
      yaw_drive_o      <= yaw_w_q;
      altitude_drive_o <= alt_w_q;
    end
  end

endmodule

>>> rtl/core/attitude_altitude_pid_bank.sv
// Five-channel PID bank (pitch, roll, yaw, altitude, vertical acceleration)
// with clamped integrals and a fixed 0.01 s step. A control step runs each
// channel in turn through the single shared 29x28 multiplier (reciprocal
// divide for the integral increment, then the P, I and D products) and then
// publishes; the input stalls from acceptance until that publish, so a new
// beat is taken only once the previous step has published. A clear beat
// gives no result. The next beat is accepted while a published result still
// waits in the output register; if a finished step finds that register still
// stalled, it holds and the input stalls until the register frees up.
`include "attitude_altitude_pid_bank_macros.svh"

module attitude_altitude_pid_bank (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [aapb_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 cmd_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] pitch_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] roll_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] yaw_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] altitude_target_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] pitch_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] roll_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] yaw_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] altitude_meas_i,
  input  logic signed [aapb_pkg::SAMPLE_W-1:0] vertical_accel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [aapb_pkg::DRIVE_W-1:0]  roll_drive_o,
  output logic signed [aapb_pkg::DRIVE_W-1:0]  pitch_drive_o,
  output logic signed [aapb_pkg::DRIVE_W-1:0]  yaw_drive_o,
  output logic signed [aapb_pkg::ALT_W-1:0]    altitude_drive_o
);

  aapb_pkg::cmd_t    cmd;
  aapb_pkg::status_t status;

  aapb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aapb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .pitch_target_i    (pitch_target_i),
    .roll_target_i     (roll_target_i),
    .yaw_target_i      (yaw_target_i),
    .altitude_target_i (altitude_target_i),
    .pitch_meas_i      (pitch_meas_i),
    .roll_meas_i       (roll_meas_i),
    .yaw_meas_i        (yaw_meas_i),
    .altitude_meas_i   (altitude_meas_i),
    .vertical_accel_i  (vertical_accel_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .roll_drive_o      (roll_drive_o),
    .pitch_drive_o     (pitch_drive_o),
    .yaw_drive_o       (yaw_drive_o),
    .altitude_drive_o  (altitude_drive_o)
  );

  `AAPB_ASSERT_NEXT(a_step_busy, in_valid_i && !in_stall_o && !cmd_i, in_stall_o)
  `AAPB_ASSERT_SAME(a_pub_free, cmd.op == aapb_pkg::OP_PUBLISH, !(out_valid_o && out_stall_i))
  `AAPB_ASSERT_SAME(a_alt_range, out_valid_o,
                    (altitude_drive_o <= aapb_pkg::ALT_LIMIT) && (altitude_drive_o >= -aapb_pkg::ALT_LIMIT))

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [16:0] alt;
  } drive_t;

  // predictor and expected-drive store
  class pid_scoreboard;
    logic [47:0] gain_reg [aapb_pkg::NUM_CH];
    longint integ [aapb_pkg::NUM_CH];
    longint prev_err [aapb_pkg::NUM_CH];
    bit primed [aapb_pkg::NUM_CH];
    drive_t pending [$];
    int errors;

    function new();
      foreach (gain_reg[i]) gain_reg[i] = '0;
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      foreach (integ[i]) begin
        integ[i] = 0;
        prev_err[i] = 0;
        primed[i] = 0;
      end
    endfunction

    function longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // returns Q.8 channel sum
    function longint channel_sum(aapb_pkg::chan_e ch, longint e);
      longint kp, ki, kd, d;
      kp = longint'($signed(gain_reg[ch][47:32]));
      ki = longint'($signed(gain_reg[ch][31:16]));
      kd = longint'($signed(gain_reg[ch][15:0]));
      if (!primed[ch]) begin
        prev_err[ch] = e;
        primed[ch] = 1;
      end
      integ[ch] = clip(integ[ch] + floor_div(e * 256 + 50, 100), -6553600, 6553600);
      d = (e - prev_err[ch]) * 100;
      prev_err[ch] = e;
      return kp * e + floor_div(ki * integ[ch], 256) + kd * d;
    endfunction

    function void note_input(bit clr, longint tp, longint tr, longint ty, longint ta,
                             longint mp, longint mr, longint my, longint ma,
                             longint va);
      longint ey, sr, sp, sy, sa;
      drive_t x;
      if (clr) begin
        clear_state();
        return;
      end
      ey = ty - my;
      if (ey > 46080) ey -= 92160;
      else if (ey < -46080) ey += 92160;
      sr = channel_sum(aapb_pkg::CH_ROLL, tr - mr);
      sp = channel_sum(aapb_pkg::CH_PITCH, tp - mp);
      sy = channel_sum(aapb_pkg::CH_YAW, ey);
      sa = channel_sum(aapb_pkg::CH_ALT, ta - ma);
      sa += channel_sum(aapb_pkg::CH_VACC, -va);
      x.roll = 32'(clip(floor_div(sr + 128, 256), -64'sd2147483648, 64'sd2147483647));
      x.pitch = 32'(clip(floor_div(sp + 128, 256), -64'sd2147483648, 64'sd2147483647));
      x.yaw = 32'(clip(floor_div(sy + 128, 256), -64'sd2147483648, 64'sd2147483647));
      x.alt = 17'(clip(floor_div(sa + 128, 256), -38400, 38400));
      pending.push_back(x);
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (pending.size() == 0) begin
        report("unexpected drive beat", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.roll !== want.roll) report("roll_drive", got.roll, want.roll);
      if (got.pitch !== want.pitch) report("pitch_drive", got.pitch, want.pitch);
      if (got.yaw !== want.yaw) report("yaw_drive", got.yaw, want.yaw);
      if (got.alt !== want.alt) report("altitude_drive", got.alt, want.alt);
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d", what, got, want);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [aapb_pkg::GAIN_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic cmd_i = 0;
  logic signed [aapb_pkg::SAMPLE_W-1:0] pitch_target_i = '0, roll_target_i = '0;
  logic signed [aapb_pkg::SAMPLE_W-1:0] yaw_target_i = '0, altitude_target_i = '0;
  logic signed [aapb_pkg::SAMPLE_W-1:0] pitch_meas_i = '0, roll_meas_i = '0;
  logic signed [aapb_pkg::SAMPLE_W-1:0] yaw_meas_i = '0, altitude_meas_i = '0;
  logic signed [aapb_pkg::SAMPLE_W-1:0] vertical_accel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [aapb_pkg::DRIVE_W-1:0] roll_drive_o, pitch_drive_o, yaw_drive_o;
  logic signed [aapb_pkg::ALT_W-1:0] altitude_drive_o;

  attitude_altitude_pid_bank u_dut (.*);

  pid_scoreboard board = new();
  int cycles = 0;
  bit rx_random = 0;
  bit hold_rx = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls per beat, plus a forced long hold-off
  always @(posedge clk_i) begin
    drive_t got;
    if (out_valid_o && !out_stall_i) begin
      got.roll = roll_drive_o;
      got.pitch = pitch_drive_o;
      got.yaw = yaw_drive_o;
      got.alt = altitude_drive_o;
      board.check_drive(got);
    end
  end

  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) out_stall_i <= 1;
      else if (!rx_random) out_stall_i <= 0;
      else if (out_stall_i == 0 && out_valid_o) begin
        // the beat is taken now; draw a stall for the next one
        wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        out_stall_i <= (wait_left != 0);
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= (wait_left != 0);
      end else out_stall_i <= 0;
    end
  end

  task automatic write_gain(int idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= 3'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx < aapb_pkg::NUM_CH) board.gain_reg[idx] = val;
  endtask

  task automatic send_beat(bit clr, logic [aapb_pkg::SAMPLE_W-1:0] f [9], int gap);
    repeat (gap) @(posedge clk_i);
    if (gap == 0) @(posedge clk_i);
    in_valid_i <= 1;
    cmd_i <= clr;
    pitch_target_i <= f[0];
    roll_target_i <= f[1];
    yaw_target_i <= f[2];
    altitude_target_i <= f[3];
    pitch_meas_i <= f[4];
    roll_meas_i <= f[5];
    yaw_meas_i <= f[6];
    altitude_meas_i <= f[7];
    vertical_accel_i <= f[8];
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(clr, $signed(f[0]), $signed(f[1]), $signed(f[2]), $signed(f[3]),
                     $signed(f[4]), $signed(f[5]), $signed(f[6]), $signed(f[7]),
                     $signed(f[8]));
    in_valid_i <= 0;
  endtask

  function automatic logic [aapb_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return aapb_pkg::SAMPLE_W'($urandom);
      1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return aapb_pkg::SAMPLE_W'($signed($urandom_range(0, 120000)) - 60000);
    endcase
  endfunction

  function automatic logic [47:0] pick_gains();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? 48'h7fff7fff7fff : 48'h800080008000;
      default: return {16'($signed($urandom_range(0, 1024)) - 512),
                       16'($signed($urandom_range(0, 1024)) - 512),
                       16'($signed($urandom_range(0, 64)) - 32)};
    endcase
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_beat(int gap_max);
    logic [aapb_pkg::SAMPLE_W-1:0] f [9];
    foreach (f[i]) f[i] = pick_sample();
    send_beat($urandom_range(0, 19) == 0, f, $urandom_range(0, gap_max));
  endtask

  initial begin
    logic [aapb_pkg::SAMPLE_W-1:0] f [9];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    // directed: extremes, clear, first step after clear, yaw wrap both ways
    for (int i = 0; i < aapb_pkg::NUM_CH; i++) write_gain(i, 48'h0100_0040_0010);
    write_gain(7, 48'hffff_ffff_ffff);
    foreach (f[i]) f[i] = '0;
    send_beat(0, f, 0);
    foreach (f[i]) f[i] = 24'h7fffff;
    send_beat(0, f, 0);
    foreach (f[i]) f[i] = (i < 4) ? 24'h7fffff : 24'h800000;
    send_beat(0, f, 0);
    send_beat(0, f, 0);
    foreach (f[i]) f[i] = (i < 4) ? 24'h800000 : 24'h7fffff;
    send_beat(0, f, 0);
    send_beat(1, f, 0);
    send_beat(0, f, 0);
    send_beat(0, f, 0);
    foreach (f[i]) f[i] = '0;
    f[2] = 24'd46081;  send_beat(0, f, 0);
    f[2] = -24'sd46081; send_beat(0, f, 0);
    f[2] = 24'd46080;  send_beat(0, f, 0);
    f[2] = 24'd200000; send_beat(0, f, 0);
    f[2] = 24'd0; f[6] = 24'd200000; send_beat(0, f, 0);
    for (int i = 0; i < 5; i++) begin
      foreach (f[j]) f[j] = aapb_pkg::SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
      send_beat(0, f, 0);
    end
    drain();
    rx_random = 1;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        for (int i = 0; i < aapb_pkg::NUM_CH; i++) write_gain(i, 48'h7fff7fff7fff);
      end else if (ph == 1) begin
        for (int i = 0; i < aapb_pkg::NUM_CH; i++) write_gain(i, 48'h800080008000);
      end else begin
        for (int i = 0; i < aapb_pkg::NUM_CH; i++) write_gain(i, pick_gains());
      end
      if (ph == 3) begin
        // receiver holds off while the sender keeps going
        fork
          begin
            hold_rx = 1;
            repeat (400) @(posedge clk_i);
            hold_rx = 0;
          end
          for (int k = 0; k < 6; k++) random_beat(0);
        join
      end
      for (int k = 0; k < 48; k++) random_beat(($urandom_range(0, 3) == 0) ? 0 : 15);
      // sender pauses until every drive is back
      drain();
    end
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
